// ----- rtl/ptw_pkg.sv -----
// Shared types and constants for the page table walker.
// Used by the top level and by its port checker; depends on nothing else.
`default_nettype none
package ptw_pkg;

   localparam int unsigned IDX_W = 9;
   localparam int unsigned PPN_W = 44;
   localparam int unsigned VA_W = 48;
   localparam int unsigned PTE_W = 64;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 44;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_MISSING = 2'd1,
      ST_EXHAUSTED = 2'd2,
      ST_OUTSIDE = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROOT_LEVEL = 2'd0,
      CSR_ROOT_TABLE = 2'd1,
      CSR_POOL_BASE = 2'd2,
      CSR_UNUSED = 2'd3
   } csr_index_type;

   localparam logic OP_WALK = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [1:0] RESET_ROOT_LEVEL = 2'd3;
   localparam logic [5:0] RESET_ROOT_TABLE = 6'd0;
   localparam logic [PPN_W-1:0] RESET_POOL_BASE = 44'd524288;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE = 8'b0000_0010,
      S_RD = 8'b0000_0100,
      S_EVAL = 8'b0000_1000,
      S_FILL = 8'b0001_0000,
      S_LINK = 8'b0010_0000,
      S_FRD = 8'b0100_0000,
      S_FWAIT = 8'b1000_0000
   } state_type;

   // Nine index bits of the virtual address for one level.
   function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                   input logic [1:0] level);
      logic [IDX_W-1:0] ix;
      case (level)
         2'd0: ix = va[20:12];
         2'd1: ix = va[29:21];
         2'd2: ix = va[38:30];
         default: ix = va[47:39];
      endcase
      return ix;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/page_table_walk_allocate_split.sv -----
// Page table walker with table allocation and leaf splitting.
// Depends on ptw_pkg for state, status and register index codes.
`default_nettype none
// Usage
// The block keeps a pool of NUM_TABLES page tables of 512 entries in one
// synchronous memory. An item is transferred when start is high and busy is
// low. A write item stores req_write_value into one entry, or reports
// ST_OUTSIDE for a table beyond the pool; its result is registered and comes
// in the cycle after the transfer. A walk item descends from the configured
// root level to req_target_level. Each level is a memory read, then an
// evaluation; the final entry is then read and returned.
// When create is set and an entry is absent, a fresh table is taken from the
// bump allocator and zeroed; a covering leaf is split into 512 finer leaves.
// Either case sweeps 512 entries through the single write port, one per
// cycle, and then writes the new pointer.
// Each result is shown for one cycle with rsp_valid high; the receiver cannot
// stall, so results are never held back.
// After reset the whole memory is cleared, one entry per cycle, while busy
// stays high. Register writes on the csr_ port are taken at any time and
// should be made while the block is idle.
module page_table_walk_allocate_split #(
   parameter int unsigned NUM_TABLES = 64
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic csr_we,
   input wire logic [ptw_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [ptw_pkg::CSR_DATA_W-1:0] csr_wdata,
   input wire logic req_operation,
   input wire logic [47:0] req_virtual_address,
   input wire logic [1:0] req_target_level,
   input wire logic req_create,
   input wire logic [5:0] req_write_table,
   input wire logic [8:0] req_write_slot,
   input wire logic [63:0] req_write_value,
   output logic rsp_valid,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_found_table,
   output logic [8:0] rsp_found_slot,
   output logic [63:0] rsp_found_value,
   output logic rsp_flush_needed
);

   localparam int unsigned TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int unsigned UW = $clog2(NUM_TABLES + 1);
   localparam int unsigned AW = TW + ptw_pkg::IDX_W;
   localparam int unsigned DEPTH = NUM_TABLES * 512;
   localparam int unsigned PW = ptw_pkg::PPN_W;

   // Configuration registers.
   logic [1:0] root_level_ff;
   logic [5:0] root_table_ff;
   logic [PW-1:0] pool_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_level_ff <= ptw_pkg::RESET_ROOT_LEVEL;
         root_table_ff <= ptw_pkg::RESET_ROOT_TABLE;
         pool_base_ff <= ptw_pkg::RESET_POOL_BASE;
      end else if (csr_we) begin
         unique case (ptw_pkg::csr_index_type'(csr_index))
            ptw_pkg::CSR_ROOT_LEVEL: root_level_ff <= csr_wdata[1:0];
            ptw_pkg::CSR_ROOT_TABLE: root_table_ff <= csr_wdata[5:0];
            ptw_pkg::CSR_POOL_BASE: pool_base_ff <= csr_wdata[PW-1:0];
            default: ;
         endcase
      end
   end

   // Walk state.
   ptw_pkg::state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [UW-1:0] used_ff, used_in;
   logic [TW-1:0] t_ff, t_in;
   logic [TW-1:0] nt_ff, nt_in;
   logic [1:0] level_ff, level_in;
   logic [47:0] va_ff, va_in;
   logic [1:0] target_ff, target_in;
   logic create_ff, create_in;
   logic flush_ff, flush_in;
   logic split_ff, split_in;
   logic [8:0] fill_ff, fill_in;
   logic [PW-1:0] cp_ff, cp_in;
   logic [PW-1:0] span_ff, span_in;
   logic [7:0] keep_ff, keep_in;

   // Registered result.
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [5:0] rsp_table_ff, rsp_table_in;
   logic [8:0] rsp_slot_ff, rsp_slot_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic rsp_flush_ff, rsp_flush_in;

   // Table memory: one write port, one registered read port.
   logic [63:0] mem [0:DEPTH-1];
   logic mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_raddr;
   logic [63:0] mem_wdata;
   logic [63:0] mem_q;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q <= mem[mem_raddr];
   end

   logic [8:0] ix_cur;
   logic [8:0] ix_target;
   logic [PW-1:0] entry_ppn;
   logic [PW-1:0] entry_off;
   logic [PW-1:0] link_ppn;
   logic entry_v;
   logic entry_rwx;

   assign ix_cur = ptw_pkg::level_index(va_ff, level_ff);
   assign ix_target = ptw_pkg::level_index(va_ff, target_ff);
   assign entry_v = mem_q[0];
   assign entry_rwx = |mem_q[3:1];
   assign entry_ppn = mem_q[53:10];
   assign entry_off = entry_ppn - pool_base_ff;
   assign link_ppn = pool_base_ff + PW'(nt_ff);

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      used_in = used_ff;
      t_in = t_ff;
      nt_in = nt_ff;
      level_in = level_ff;
      va_in = va_ff;
      target_in = target_ff;
      create_in = create_ff;
      flush_in = flush_ff;
      split_in = split_ff;
      fill_in = fill_ff;
      cp_in = cp_ff;
      span_in = span_ff;
      keep_in = keep_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_table_in = rsp_table_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_value_in = rsp_value_ff;
      rsp_flush_in = rsp_flush_ff;
      mem_we = 1'b0;
      mem_waddr = {t_ff, ix_cur};
      mem_wdata = '0;
      mem_raddr = {t_ff, ix_cur};

      unique case (state_ff)
         ptw_pkg::S_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ptw_pkg::S_IDLE;
            end
         end
         ptw_pkg::S_IDLE: begin
            if (start) begin
               if (req_operation == ptw_pkg::OP_WRITE) begin
                  rsp_valid_in = 1'b1;
                  rsp_flush_in = 1'b0;
                  if (32'(req_write_table) >= NUM_TABLES) begin
                     rsp_status_in = ptw_pkg::ST_OUTSIDE;
                     rsp_table_in = '0;
                     rsp_slot_in = '0;
                     rsp_value_in = '0;
                  end else begin
                     mem_we = 1'b1;
                     mem_waddr = {TW'(req_write_table), req_write_slot};
                     mem_wdata = req_write_value;
                     rsp_status_in = ptw_pkg::ST_OK;
                     rsp_table_in = req_write_table;
                     rsp_slot_in = req_write_slot;
                     rsp_value_in = req_write_value;
                  end
               end else if (32'(root_table_ff) >= NUM_TABLES) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = ptw_pkg::ST_OUTSIDE;
                  rsp_table_in = '0;
                  rsp_slot_in = '0;
                  rsp_value_in = '0;
                  rsp_flush_in = 1'b0;
               end else begin
                  va_in = req_virtual_address;
                  target_in = req_target_level;
                  create_in = req_create;
                  flush_in = 1'b0;
                  t_in = TW'(root_table_ff);
                  level_in = root_level_ff;
                  state_in = (root_level_ff > req_target_level) ?
                             ptw_pkg::S_RD : ptw_pkg::S_FRD;
               end
            end
         end
         ptw_pkg::S_RD: begin
            state_in = ptw_pkg::S_EVAL;
         end
         ptw_pkg::S_EVAL: begin
            if (!entry_v || entry_rwx) begin
               if (!create_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = ptw_pkg::ST_MISSING;
                  rsp_table_in = '0;
                  rsp_slot_in = '0;
                  rsp_value_in = '0;
                  rsp_flush_in = flush_ff;
                  state_in = ptw_pkg::S_IDLE;
               end else if (used_ff >= UW'(NUM_TABLES)) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = ptw_pkg::ST_EXHAUSTED;
                  rsp_table_in = '0;
                  rsp_slot_in = '0;
                  rsp_value_in = '0;
                  rsp_flush_in = flush_ff;
                  state_in = ptw_pkg::S_IDLE;
               end else begin
                  // A valid leaf is split; an absent entry gets a zeroed table.
                  nt_in = used_ff[TW-1:0];
                  used_in = used_ff + UW'(1);
                  fill_in = '0;
                  split_in = entry_v;
                  cp_in = entry_ppn;
                  keep_in = mem_q[8:1];
                  span_in = PW'(1) << (9 * (level_ff - 2'd1));
                  if (entry_v) begin
                     flush_in = 1'b1;
                  end
                  state_in = ptw_pkg::S_FILL;
               end
            end else if (entry_off >= PW'(NUM_TABLES)) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ptw_pkg::ST_OUTSIDE;
               rsp_table_in = '0;
               rsp_slot_in = '0;
               rsp_value_in = '0;
               rsp_flush_in = flush_ff;
               state_in = ptw_pkg::S_IDLE;
            end else begin
               t_in = entry_off[TW-1:0];
               level_in = level_ff - 2'd1;
               state_in = ((level_ff - 2'd1) > target_ff) ?
                          ptw_pkg::S_RD : ptw_pkg::S_FRD;
            end
         end
         ptw_pkg::S_FILL: begin
            mem_we = 1'b1;
            mem_waddr = {nt_ff, fill_ff};
            mem_wdata = split_ff ? {10'b0, cp_ff, 1'b0, keep_ff, 1'b1} : '0;
            cp_in = cp_ff + span_ff;
            fill_in = fill_ff + 9'd1;
            if (fill_ff == 9'd511) begin
               state_in = ptw_pkg::S_LINK;
            end
         end
         ptw_pkg::S_LINK: begin
            mem_we = 1'b1;
            mem_waddr = {t_ff, ix_cur};
            mem_wdata = {10'b0, link_ppn, 9'b0, 1'b1};
            t_in = nt_ff;
            level_in = level_ff - 2'd1;
            state_in = ((level_ff - 2'd1) > target_ff) ?
                       ptw_pkg::S_RD : ptw_pkg::S_FRD;
         end
         ptw_pkg::S_FRD: begin
            mem_raddr = {t_ff, ix_target};
            state_in = ptw_pkg::S_FWAIT;
         end
         ptw_pkg::S_FWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_status_in = ptw_pkg::ST_OK;
            rsp_table_in = 6'(t_ff);
            rsp_slot_in = ix_target;
            rsp_value_in = mem_q;
            rsp_flush_in = flush_ff;
            state_in = ptw_pkg::S_IDLE;
         end
         default: begin
            state_in = ptw_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptw_pkg::S_CLEAR;
         clr_ff <= '0;
         used_ff <= UW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      nt_ff <= nt_in;
      level_ff <= level_in;
      va_ff <= va_in;
      target_ff <= target_in;
      create_ff <= create_in;
      flush_ff <= flush_in;
      split_ff <= split_in;
      fill_ff <= fill_in;
      cp_ff <= cp_in;
      span_ff <= span_in;
      keep_ff <= keep_in;
      rsp_status_ff <= rsp_status_in;
      rsp_table_ff <= rsp_table_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flush_ff <= rsp_flush_in;
   end

   assign busy = (state_ff != ptw_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_table = rsp_table_ff;
   assign rsp_found_slot = rsp_slot_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_flush_needed = rsp_flush_ff;

endmodule
`default_nettype wire

// ----- rtl/ptw_checker.sv -----
// Port-level checks for the page table walker, bound to its top level.
// Depends on ptw_pkg for the status codes.
`default_nettype none
module ptw_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic [1:0] rsp_status,
   input wire logic [5:0] rsp_found_table,
   input wire logic [8:0] rsp_found_slot,
   input wire logic [63:0] rsp_found_value
);

   // The memory clear after reset keeps the block busy.
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("block idle right after reset");

   // Every result follows either a transfer or a cycle of work.
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result without a preceding transfer or work");

   // A failed item reports no location and no value.
   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ptw_pkg::ST_OK) |->
         (rsp_found_value == 64'd0 && rsp_found_table == 6'd0 &&
          rsp_found_slot == 9'd0))
      else $error("failed result carries a location");

endmodule

bind page_table_walk_allocate_split ptw_checker u_ptw_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_status(rsp_status),
   .rsp_found_table(rsp_found_table),
   .rsp_found_slot(rsp_found_slot),
   .rsp_found_value(rsp_found_value)
);
`default_nettype wire
